@@ sv/tscc_pkg.sv @@
// Shared types and constants for the temperature compensation and band classifier.
// Used by the top level and every module of the block; no dependencies.

package tscc_pkg;

    localparam int unsigned NUM_STAGES  = 5;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CAL_OFFSET = 3'd0,
        REG_CAL_LINEAR = 3'd1,
        REG_CAL_SQUARE = 3'd2,
        REG_COLD_LIMIT = 3'd3,
        REG_HOT_LIMIT  = 3'd4
    } reg_index_t;

    localparam logic [1:0] BAND_COLD   = 2'd0;
    localparam logic [1:0] BAND_NORMAL = 2'd1;
    localparam logic [1:0] BAND_HOT    = 2'd2;

    localparam logic signed [15:0] COLD_LIMIT_RESET = 16'sd2000;
    localparam logic signed [15:0] HOT_LIMIT_RESET  = 16'sd3500;
    localparam logic signed [24:0] CENTI_ROUND      = 25'sd128;
    localparam logic signed [15:0] CENTI_MAX        = 16'sh7FFF;
    localparam logic signed [15:0] CENTI_MIN        = 16'sh8000;

    typedef struct packed {
        logic        [15:0] offset;
        logic signed [15:0] linear;
        logic signed [15:0] square;
        logic signed [15:0] cold_limit;
        logic signed [15:0] hot_limit;
    } cal_cfg_t;

    // (r>>3) - 2*T1 and (r>>4) - T1
    typedef struct packed {
        logic signed [17:0] lin_diff;
        logic signed [16:0] sq_diff;
    } front_t;

    // linear term and squared difference, both already shifted
    typedef struct packed {
        logic signed [20:0] lin;
        logic signed [19:0] sq;
    } mid_t;

    typedef struct packed {
        logic signed [20:0] lin;
        logic signed [17:0] quad;
    } term_t;

    typedef logic signed [21:0] fine_t;

endpackage

@@ sv/tscc_in_if.sv @@
// Input channel: one raw sensor reading per item.
// Depends on nothing.

interface tscc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_high_byte;
    logic [7:0] raw_mid_byte;
    logic [7:0] raw_low_byte;

    modport source (output valid, raw_high_byte, raw_mid_byte, raw_low_byte, input ready);
    modport sink   (input valid, raw_high_byte, raw_mid_byte, raw_low_byte, output ready);
endinterface

@@ sv/tscc_out_if.sv @@
// Result channel: compensated temperature and band per item.
// Depends on nothing.

interface tscc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temperature;
    logic signed [15:0] temperature_centi;
    logic        [1:0]  temp_band;

    modport source (output valid, fine_temperature, temperature_centi, temp_band,
                    input ready);
    modport sink   (input valid, fine_temperature, temperature_centi, temp_band,
                    output ready);
endinterface

@@ sv/temp_sensor_compensate_classify_core.sv @@
// Top level of the temperature compensation and band classifier.
// Depends on tscc_pkg, tscc_in_if, tscc_out_if, tscc_front, tscc_mult, tscc_scale.
//
// Usage:
//   raw    : valid/ready channel of raw readings (three register bytes per item).
//   result : valid/ready channel of fine temperature, centidegrees (saturated
//            to 16 bits signed) and band (cold, normal, hot).
//   cfg_*  : write port for the three calibration words and the two band limits;
//            write only while no item is in flight.
// Every item gives exactly one result via front, mid, term, fine, result stages.
// The five-stage pipeline takes one item per cycle while raw ready is high.
// Each stage holds its item while the next one is full, so a stall at the
// result side backs up stage by stage; empty stages keep filling, and raw
// ready drops only once every stage holds an item. Nothing is lost or repeated.
// Reset empties the pipeline and loads the registers with their defaults:
// calibration words zero, cold limit 2000, hot limit 3500.

module temp_sensor_compensate_classify_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    tscc_in_if.sink                             raw,
    tscc_out_if.source                          result,
    input  logic                                cfg_write,
    input  logic [tscc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tscc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned N = tscc_pkg::NUM_STAGES;

    tscc_pkg::cal_cfg_t cal_reg;
    tscc_pkg::cal_cfg_t cal_next;
    logic [N-1:0]       valid_reg;
    logic [N-1:0]       valid_next;
    logic [N-1:0]       valid_prev;
    logic [N-1:0]       free;
    logic [N-1:0]       load;
    tscc_pkg::front_t   front;
    tscc_pkg::term_t    term;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_write)
        begin
            case (tscc_pkg::reg_index_t'(cfg_index))
                tscc_pkg::REG_CAL_OFFSET: cal_next.offset     = cfg_data;
                tscc_pkg::REG_CAL_LINEAR: cal_next.linear     = $signed(cfg_data);
                tscc_pkg::REG_CAL_SQUARE: cal_next.square     = $signed(cfg_data);
                tscc_pkg::REG_COLD_LIMIT: cal_next.cold_limit = $signed(cfg_data);
                tscc_pkg::REG_HOT_LIMIT:  cal_next.hot_limit  = $signed(cfg_data);
                default:                  cal_next = cal_reg;
            endcase
        end
    end

    // a stage is free when empty or when its item moves on this cycle
    always_comb
    begin
        free[N-1] = ~valid_reg[N-1] | result.ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            free[k] = ~valid_reg[k] | free[k+1];
        end
        valid_prev = {valid_reg[N-2:0], raw.valid};
        load       = free & valid_prev;
        valid_next = (free & valid_prev) | (~free & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= '0;
            cal_reg.offset     <= '0;
            cal_reg.linear     <= '0;
            cal_reg.square     <= '0;
            cal_reg.cold_limit <= tscc_pkg::COLD_LIMIT_RESET;
            cal_reg.hot_limit  <= tscc_pkg::HOT_LIMIT_RESET;
        end
        else
        begin
            valid_reg <= valid_next;
            cal_reg   <= cal_next;
        end
    end

    assign raw.ready    = free[0];
    assign result.valid = valid_reg[N-1];

    tscc_front u_front
    (
        .clk            (clk),
        .load           (load[0]),
        .raw_high_byte  (raw.raw_high_byte),
        .raw_mid_byte   (raw.raw_mid_byte),
        .raw_low_byte   (raw.raw_low_byte),
        .cal_offset     (cal_reg.offset),
        .front          (front)
    );

    tscc_mult u_mult
    (
        .clk        (clk),
        .load_mid   (load[1]),
        .load_term  (load[2]),
        .front      (front),
        .cal        (cal_reg),
        .term       (term)
    );

    tscc_scale u_scale
    (
        .clk                (clk),
        .load_fine          (load[3]),
        .load_result        (load[4]),
        .term               (term),
        .cal                (cal_reg),
        .fine_temperature   (result.fine_temperature),
        .temperature_centi  (result.temperature_centi),
        .temp_band          (result.temp_band)
    );

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> raw.ready)
        else $error("input blocked with empty result stage");

    a_ready_when_taken: assert property (@(posedge clk) disable iff (!rst_n)
        result.ready |-> raw.ready)
        else $error("input blocked while result side is ready");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        raw.valid && raw.ready |=> valid_reg[0])
        else $error("accepted item missing from first stage");

    a_band_cold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
            ((result.temp_band == tscc_pkg::BAND_COLD)
             == (result.temperature_centi < cal_reg.cold_limit)))
        else $error("cold band does not match cold limit");

endmodule

@@ sv/tscc_front.sv @@
// Stage 1: assembles the 20-bit reading and forms both offset differences.
// Depends on tscc_pkg.

module tscc_front
(
    input  logic                clk,
    input  logic                load,
    input  logic [7:0]          raw_high_byte,
    input  logic [7:0]          raw_mid_byte,
    input  logic [7:0]          raw_low_byte,
    input  logic [15:0]         cal_offset,
    output tscc_pkg::front_t    front
);

    logic [19:0]        reading;
    tscc_pkg::front_t   front_next;
    tscc_pkg::front_t   front_reg;

    assign reading = {raw_high_byte, raw_mid_byte, raw_low_byte[7:4]};

    always_comb
    begin
        front_next.lin_diff = $signed({1'b0, reading[19:3]}) - $signed({1'b0, cal_offset, 1'b0});
        front_next.sq_diff  = $signed({1'b0, reading[19:4]}) - $signed({1'b0, cal_offset});
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

@@ sv/tscc_mult.sv @@
// Stages 2 and 3: linear product and square, then the quadratic product.
// Products wrap to 32 bits before the arithmetic shift. Depends on tscc_pkg.

module tscc_mult
(
    input  logic                clk,
    input  logic                load_mid,
    input  logic                load_term,
    input  tscc_pkg::front_t    front,
    input  tscc_pkg::cal_cfg_t  cal,
    output tscc_pkg::term_t     term
);

    logic signed [33:0] lin_prod;
    logic signed [33:0] sq_prod;
    logic signed [35:0] quad_prod;
    tscc_pkg::mid_t     mid_next;
    tscc_pkg::mid_t     mid_reg;
    tscc_pkg::term_t    term_next;
    tscc_pkg::term_t    term_reg;

    always_comb
    begin
        lin_prod      = front.lin_diff * cal.linear;
        sq_prod       = front.sq_diff * front.sq_diff;
        mid_next.lin  = lin_prod[31:11];
        mid_next.sq   = sq_prod[31:12];
    end

    always_comb
    begin
        quad_prod      = mid_reg.sq * cal.square;
        term_next.lin  = mid_reg.lin;
        term_next.quad = quad_prod[31:14];
    end

    always_ff @(posedge clk)
    begin
        if (load_mid)
        begin
            mid_reg <= mid_next;
        end
        if (load_term)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

@@ sv/tscc_scale.sv @@
// Stages 4 and 5: fine temperature sum, centidegree scaling with saturation,
// and band classification into the result register. Depends on tscc_pkg.

module tscc_scale
(
    input  logic                clk,
    input  logic                load_fine,
    input  logic                load_result,
    input  tscc_pkg::term_t     term,
    input  tscc_pkg::cal_cfg_t  cal,
    output logic signed [31:0]  fine_temperature,
    output logic signed [15:0]  temperature_centi,
    output logic [1:0]          temp_band
);

    tscc_pkg::fine_t    fine_next;
    tscc_pkg::fine_t    fine_reg;
    logic signed [24:0] centi_sum;
    logic signed [16:0] centi_wide;
    logic signed [15:0] centi_sat;
    logic [1:0]         band;
    logic signed [31:0] fine_out_reg;
    logic signed [15:0] centi_reg;
    logic [1:0]         band_reg;

    assign fine_next = $signed({term.lin[20], term.lin})
                     + $signed({{4{term.quad[17]}}, term.quad});

    always_comb
    begin
        // fine*5 + 128, then >>> 8
        centi_sum  = $signed({{3{fine_reg[21]}}, fine_reg})
                   + $signed({fine_reg[21], fine_reg, 2'b00})
                   + tscc_pkg::CENTI_ROUND;
        centi_wide = centi_sum[24:8];
        if (centi_wide[16] != centi_wide[15])
        begin
            centi_sat = centi_wide[16] ? tscc_pkg::CENTI_MIN : tscc_pkg::CENTI_MAX;
        end
        else
        begin
            centi_sat = centi_wide[15:0];
        end
        if (centi_sat < cal.cold_limit)
        begin
            band = tscc_pkg::BAND_COLD;
        end
        else if (centi_sat < cal.hot_limit)
        begin
            band = tscc_pkg::BAND_NORMAL;
        end
        else
        begin
            band = tscc_pkg::BAND_HOT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_fine)
        begin
            fine_reg <= fine_next;
        end
        if (load_result)
        begin
            fine_out_reg <= {{10{fine_reg[21]}}, fine_reg};
            centi_reg    <= centi_sat;
            band_reg     <= band;
        end
    end

    assign fine_temperature  = fine_out_reg;
    assign temperature_centi = centi_reg;
    assign temp_band         = band_reg;

endmodule
